@@ hw/rtl/sklist_pkg.sv @@
// Shared types and constants for the sorted key list core.
// Used by the core and its checker; depends on nothing else.
package sklist_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 8;
    localparam int ID_W     = 31;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_MISSING = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_EV,
        ST_RM_RD,
        ST_RM_EV,
        ST_SH_RD,
        ST_SH_EV,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } entry_t;

endpackage

@@ hw/rtl/sorted_key_list_insert_remove_core.sv @@
// Sorted key list core: a bounded table of (key, id) entries in ascending key order.
// One entry memory and one key comparator are stepped by a small sequencer.
// Depends on sklist_pkg.
// An insert reads each entry above the new key's slot and moves it up by one, then writes the
// new entry; a remove reads entries in order until it meets or passes the key, then moves each
// later entry down by one. A full insert or an empty remove goes straight to the result.
// A new beat is taken only in idle, after each result, since the single read and write port
// of the entry memory serializes the work. The result sits in an output register, so the
// next beat is taken while it waits. Reset empties the list at once; no clearing pass.
module sorted_key_list_insert_remove_core
    import sklist_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // key[7:0], item_id[38:8], zero pad
    input  logic [0:0]       s_tuser,   // mode[0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], count[6:2], removed_id[37:7], zero pad
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [ID_W-1:0]   id_reg, id_next;
    status_t           status_reg, status_next;
    logic [ID_W-1:0]   rid_reg, rid_next;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    entry_t            entry_mem [CAPACITY];
    entry_t            rd_data_reg;
    entry_t            wr_data;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    logic              accept;
    logic              out_free;
    logic              key_lt;
    logic              key_eq;
    logic              at_last;
    logic              ins_move;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Shared comparator: the latched key against the key just read.
    assign key_lt   = key_reg < rd_data_reg.key;
    assign key_eq   = key_reg == rd_data_reg.key;
    assign at_last  = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign ins_move = (idx_reg == ADDR_W'(1)) ? key_lt : (key_lt || key_eq);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == MODE_INSERT)
                    begin
                        state_next = (count_reg == CNT_W'(CAPACITY)) ? ST_RESP : ST_INS_RD;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_RESP : ST_RM_RD;
                    end
                end
            end
            ST_INS_RD: state_next = (idx_reg == '0) ? ST_RESP : ST_INS_EV;
            ST_INS_EV: state_next = ins_move ? ST_INS_RD : ST_RESP;
            ST_RM_RD:  state_next = ST_RM_EV;
            ST_RM_EV:
            begin
                if (!key_lt && !key_eq)
                begin
                    state_next = at_last ? ST_RESP : ST_RM_RD;
                end
                else if (key_eq)
                begin
                    state_next = ST_SH_RD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SH_RD:  state_next = at_last ? ST_RESP : ST_SH_EV;
            ST_SH_EV:  state_next = ST_SH_RD;
            ST_RESP:   state_next = out_free ? ST_IDLE : ST_RESP;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next    = idx_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        id_next     = id_reg;
        status_next = status_reg;
        rid_next    = rid_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        wr_addr     = idx_reg;
        rd_addr     = idx_reg;
        wr_data     = '{key: key_reg, id: id_reg};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next    = s_tdata[KEY_W-1:0];
                    id_next     = s_tdata[KEY_W +: ID_W];
                    rid_next    = '0;
                    status_next = STAT_OK;
                    if (s_tuser[0] == MODE_INSERT)
                    begin
                        idx_next = ADDR_W'(count_reg);
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                        end
                    end
                    else
                    begin
                        idx_next = '0;
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                end
            end
            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    mem_re  = 1'b1;
                    rd_addr = idx_reg - ADDR_W'(1);
                end
            end
            ST_INS_EV:
            begin
                mem_we = 1'b1;
                if (ins_move)
                begin
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg - ADDR_W'(1);
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_RM_RD:
            begin
                mem_re = 1'b1;
            end
            ST_RM_EV:
            begin
                if (!key_lt && !key_eq)
                begin
                    if (at_last)
                    begin
                        status_next = STAT_MISSING;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
                else if (key_eq)
                begin
                    rid_next = rd_data_reg.id;
                end
                else
                begin
                    status_next = STAT_MISSING;
                end
            end
            ST_SH_RD:
            begin
                if (at_last)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    mem_re  = 1'b1;
                    rd_addr = idx_reg + ADDR_W'(1);
                end
            end
            ST_SH_EV:
            begin
                mem_we   = 1'b1;
                wr_data  = rd_data_reg;
                idx_next = idx_reg + ADDR_W'(1);
            end
            ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        id_reg     <= id_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        if ((state_reg == ST_RESP) && out_free)
        begin
            out_data_reg <= {{(OUT_W - STATUS_W - COUNT_W - ID_W){1'b0}}, rid_reg,
                             COUNT_W'(count_reg), status_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if ((state_reg == ST_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/sklist_chk.sv @@
// Port-level checker for the sorted key list core, bound to the top level.
// Depends on sklist_pkg and sorted_key_list_insert_remove_core.
module sklist_chk
    import sklist_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic [0:0]       s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] out_status;
    logic [COUNT_W-1:0]  out_count;
    logic [ID_W-1:0]     out_rid;

    assign out_status = m_tdata[STATUS_W-1:0];
    assign out_count  = m_tdata[STATUS_W +: COUNT_W];
    assign out_rid    = m_tdata[STATUS_W + COUNT_W +: ID_W];

    // The core is busy with each item it accepts and drops s_tready until it is done.
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("core took two input beats in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    a_rid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status != STAT_OK) |-> out_rid == '0)
        else $error("removed id set on a failed item");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status == STAT_FULL) |-> out_count == COUNT_W'(CAPACITY))
        else $error("full status with a count below capacity");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_count <= COUNT_W'(CAPACITY))
        else $error("count above capacity");

endmodule

bind sorted_key_list_insert_remove_core sklist_chk u_sklist_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/sorted_key_list_insert_remove_core_test.sv @@
// Self-checking test for the sorted key list core: it drives insert and remove beats
// with random gaps and stalls and checks each reply against a tracked copy of the list.
// Depends on sklist_pkg and sorted_key_list_insert_remove_core.
module sorted_key_list_insert_remove_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sklist_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 19;
    localparam int PHASE_LEN  = 100;

    typedef enum int {
        KEYS_FULL,
        KEYS_NARROW,
        KEYS_EDGES
    } key_style_t;

    class entry_table_tracker;
        typedef struct {
            status_t            status;
            logic [COUNT_W-1:0] count;
            logic [ID_W-1:0]    removed_id;
        } reply_t;

        logic [KEY_W-1:0] keys [CAPACITY];
        logic [ID_W-1:0]  ids [CAPACITY];
        int               count;
        reply_t           awaited_replies[$];
        int               mismatches;
        int               requests;
        int               replies;
        int               status_hits [4];

        function void note_request(logic mode, logic [KEY_W-1:0] key, logic [ID_W-1:0] id);
            reply_t r;
            int     pos;
            int     i;
            r.status = STAT_OK;
            r.removed_id = '0;
            requests++;
            if (mode == MODE_INSERT)
            begin
                if (count >= CAPACITY)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    if (count == 0 || key < keys[0])
                    begin
                        pos = 0;
                    end
                    else
                    begin
                        pos = 1;
                        while (pos < count && key > keys[pos])
                            pos++;
                    end
                    for (i = count; i > pos; i--)
                    begin
                        keys[i] = keys[i-1];
                        ids[i] = ids[i-1];
                    end
                    keys[pos] = key;
                    ids[pos] = id;
                    count++;
                end
            end
            else if (count == 0)
            begin
                r.status = STAT_EMPTY;
            end
            else
            begin
                pos = 0;
                while (pos < count && keys[pos] < key)
                    pos++;
                if (pos >= count || keys[pos] != key)
                begin
                    r.status = STAT_MISSING;
                end
                else
                begin
                    r.removed_id = ids[pos];
                    for (i = pos; i + 1 < count; i++)
                    begin
                        keys[i] = keys[i+1];
                        ids[i] = ids[i+1];
                    end
                    count--;
                end
            end
            r.count = COUNT_W'(count);
            status_hits[r.status]++;
            awaited_replies.push_back(r);
        endfunction

        function void check_reply(logic [OUT_W-1:0] beat);
            reply_t             want;
            logic [1:0]         got_status;
            logic [COUNT_W-1:0] got_count;
            logic [ID_W-1:0]    got_id;
            got_status = beat[STATUS_W-1:0];
            got_count = beat[STATUS_W +: COUNT_W];
            got_id = beat[STATUS_W+COUNT_W +: ID_W];
            replies++;
            if (awaited_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply with nothing pending: status %0d count %0d id %h",
                             got_status, got_count, got_id);
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (got_status !== want.status || got_count !== want.count
                    || got_id !== want.removed_id)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply %0d: expected status %0d count %0d id %h, got %0d %0d %h",
                                 replies, want.status, want.count, want.removed_id,
                                 got_status, got_count, got_id);
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // key[7:0], item_id[38:8], zero pad
    logic [0:0]       s_tuser;   // mode[0]
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // status[1:0], count[6:2], removed_id[37:7], zero pad

    entry_table_tracker tracker;
    bit                 no_gaps;
    int                 idle_cycles;

    sorted_key_list_insert_remove_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("sorted_key_list_insert_remove_core_test: errors");
                $finish;
            end
        end
    end

    task automatic send_request(logic mode, logic [KEY_W-1:0] key, logic [ID_W-1:0] id);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {{(IN_W-KEY_W-ID_W){1'b0}}, id, key};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_request(mode, key, id);
        @(negedge clk);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (tracker.awaited_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(key_style_t style, logic [KEY_W-1:0] base);
        logic [KEY_W-1:0] key;
        case (style)
            KEYS_NARROW: key = base + KEY_W'($urandom_range(0, 3));
            KEYS_EDGES:
            begin
                case ($urandom_range(0, 3))
                    0: key = '0;
                    1: key = '1;
                    2: key = 8'h7F;
                    default: key = 8'h80;
                endcase
            end
            default: key = KEY_W'($urandom);
        endcase
        return key;
    endfunction

    task automatic run_phase(int insert_pct, key_style_t style);
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] key;
        int               n;
        base = KEY_W'($urandom);
        for (n = 0; n < PHASE_LEN; n++)
        begin
            key = pick_key(style, base);
            if ($urandom_range(0, 99) < insert_pct)
            begin
                send_request(MODE_INSERT, key, ID_W'($urandom));
            end
            else
            begin
                if (tracker.count > 0 && $urandom_range(0, 9) < 6)
                    key = tracker.keys[$urandom_range(0, tracker.count - 1)];
                send_request(MODE_REMOVE, key, ID_W'($urandom));
            end
        end
    endtask

    initial
    begin
        int p;
        int k;
        tracker = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(MODE_REMOVE, 8'd0, '0);
        send_request(MODE_INSERT, 8'd0, '0);
        send_request(MODE_INSERT, 8'd255, 31'h7FFF_FFFF);
        send_request(MODE_INSERT, 8'd128, 31'h2AAA_AAAA);
        send_request(MODE_INSERT, 8'd128, 31'h5555_5555);
        send_request(MODE_INSERT, 8'd0, 31'd1);
        send_request(MODE_REMOVE, 8'd128, 31'h7FFF_FFFF);
        send_request(MODE_REMOVE, 8'd77, '0);
        for (k = 0; k < 12; k++)
            send_request(MODE_INSERT, KEY_W'($urandom), ID_W'($urandom));
        send_request(MODE_INSERT, 8'd40, 31'h1234_5678);
        send_request(MODE_REMOVE, 8'd0, '0);
        send_request(MODE_REMOVE, 8'd255, '0);
        drain_replies();

        for (p = 0; p < PHASES; p++)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: k = 15;
                1: k = 50;
                default: k = 85;
            endcase
            run_phase(k, key_style_t'($urandom_range(0, 2)));
            if (p % 3 == 2)
                drain_replies();
        end

        no_gaps = 1'b0;
        drain_replies();
        repeat (2 * CAPACITY + 8) @(posedge clk);

        $display("Sent %0d insert/remove beats and checked %0d replies.",
                 tracker.requests, tracker.replies);
        $display("Replies seen: %0d ok, %0d empty, %0d missing key, %0d full; %0d mismatches.",
                 tracker.status_hits[STAT_OK], tracker.status_hits[STAT_EMPTY],
                 tracker.status_hits[STAT_MISSING], tracker.status_hits[STAT_FULL],
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.awaited_replies.size() == 0)
            $display("sorted_key_list_insert_remove_core_test: clean");
        else
            $display("sorted_key_list_insert_remove_core_test: errors");
        $finish;
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            tracker.check_reply(m_tdata);
            @(negedge clk);
        end
    end

endmodule

@@ sim.f @@
hw/rtl/sklist_pkg.sv
hw/rtl/sorted_key_list_insert_remove_core.sv
hw/rtl/sklist_chk.sv
tb/sv/sorted_key_list_insert_remove_core_test.sv
